// ===== design/sktab_pkg.sv =====
// ----------------------------------------------------------------------------
// sktab_pkg
// Item types and command and status codes shared by the sorted key table.
// ----------------------------------------------------------------------------
package sktab_pkg;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_FIND   = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;
    localparam logic [1:0] CMD_RANK   = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_DUP      = 3'd1;
    localparam logic [2:0] ST_NOTFOUND = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_RANK     = 3'd4;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] key;
        logic [15:0]        payload;
        logic [5:0]         rank;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] out_key;
        logic [15:0]        out_payload;
        logic [6:0]         entry_count;
    } t_out_item;

endpackage

// ===== design/sktab_store.sv =====
// ----------------------------------------------------------------------------
// sktab_store
// Key and payload memory, one write port and one registered read port.
// ----------------------------------------------------------------------------
module sktab_store #(
    parameter int DEPTH        = 64,
    parameter int PAYLOAD_BITS = 16,
    localparam int AW          = $clog2(DEPTH)
) (
    input  logic                    i_clk,
    input  logic                    i_wr_en,
    input  logic [AW-1:0]           i_wr_addr,
    input  logic signed [31:0]      i_wr_key,
    input  logic [PAYLOAD_BITS-1:0] i_wr_pay,
    input  logic [AW-1:0]           i_rd_addr,
    output logic signed [31:0]      o_rd_key,
    output logic [PAYLOAD_BITS-1:0] o_rd_pay
);

    logic signed [31:0]      r_key_mem [DEPTH];
    logic [PAYLOAD_BITS-1:0] r_pay_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_key_mem[i_wr_addr] <= i_wr_key;
            r_pay_mem[i_wr_addr] <= i_wr_pay;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rd_key <= r_key_mem[i_rd_addr];
        o_rd_pay <= r_pay_mem[i_rd_addr];
    end

endmodule

// ===== design/sktab_seq.sv =====
// ----------------------------------------------------------------------------
// sktab_seq
// Sequencer that walks the table one slot a cycle through a shared compare,
// shifting entries up on insert and down on remove in the same pass.
// ----------------------------------------------------------------------------
module sktab_seq
    import sktab_pkg::*;
#(
    parameter int DEPTH        = 64,
    parameter int PAYLOAD_BITS = 16,
    localparam int AW          = $clog2(DEPTH),
    localparam int CW          = $clog2(DEPTH + 1)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  t_in_item                i_item,
    input  logic                    i_res_free,
    output logic                    o_busy,
    output logic                    o_done,
    output t_out_item               o_res,
    output logic                    o_wr_en,
    output logic [AW-1:0]           o_wr_addr,
    output logic signed [31:0]      o_wr_key,
    output logic [PAYLOAD_BITS-1:0] o_wr_pay,
    output logic [AW-1:0]           o_rd_addr,
    input  logic signed [31:0]      i_rd_key,
    input  logic [PAYLOAD_BITS-1:0] i_rd_pay
);

    localparam int RW = (CW > 6) ? CW : 6;

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_SCAN      = 3'd1;
    localparam logic [2:0] S_SHIFT_INS = 3'd2;
    localparam logic [2:0] S_SHIFT_REM = 3'd3;
    localparam logic [2:0] S_RANK      = 3'd4;
    localparam logic [2:0] S_DONE      = 3'd5;

    logic [2:0]              r_state,     n_state;
    logic [CW-1:0]           r_idx,       n_idx;
    logic [CW-1:0]           r_count,     n_count;
    logic [1:0]              r_cmd,       n_cmd;
    logic signed [31:0]      r_key,       n_key;
    logic [PAYLOAD_BITS-1:0] r_pay,       n_pay;
    logic signed [31:0]      r_carry_key, n_carry_key;
    logic [PAYLOAD_BITS-1:0] r_carry_pay, n_carry_pay;
    logic [2:0]              r_status,    n_status;
    logic signed [31:0]      r_res_key,   n_res_key;
    logic [PAYLOAD_BITS-1:0] r_res_pay,   n_res_pay;

    logic at_end;
    logic key_lt;
    logic key_eq;
    logic full;
    logic rank_ok;

    // shared compare unit
    assign key_lt  = i_rd_key < r_key;
    assign key_eq  = i_rd_key == r_key;
    assign at_end  = r_idx == r_count;
    assign full    = r_count == CW'(DEPTH);
    assign rank_ok = RW'(i_item.rank) < RW'(r_count);

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_count     = r_count;
        n_cmd       = r_cmd;
        n_key       = r_key;
        n_pay       = r_pay;
        n_carry_key = r_carry_key;
        n_carry_pay = r_carry_pay;
        n_status    = r_status;
        n_res_key   = r_res_key;
        n_res_pay   = r_res_pay;
        o_wr_en     = 1'b0;
        o_wr_addr   = r_idx[AW-1:0];
        o_wr_key    = r_key;
        o_wr_pay    = r_pay;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_cmd     = i_item.cmd;
                    n_key     = i_item.key;
                    n_pay     = PAYLOAD_BITS'(i_item.payload);
                    n_status  = ST_OK;
                    n_res_key = '0;
                    n_res_pay = '0;
                    if (i_item.cmd == CMD_RANK) begin
                        if (rank_ok) begin
                            n_idx   = CW'(i_item.rank);
                            n_state = S_RANK;
                        end else begin
                            n_status = ST_RANK;
                            n_state  = S_DONE;
                        end
                    end else begin
                        n_idx   = '0;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (at_end) begin
                    n_state = S_DONE;
                    if (r_cmd != CMD_INSERT) begin
                        n_status = ST_NOTFOUND;
                    end else if (full) begin
                        n_status = ST_FULL;
                    end else begin
                        o_wr_en   = 1'b1;
                        n_count   = r_count + 1'b1;
                        n_res_key = r_key;
                        n_res_pay = r_pay;
                    end
                end else if (key_lt) begin
                    n_idx = r_idx + 1'b1;
                end else if (key_eq) begin
                    if (r_cmd == CMD_INSERT) begin
                        n_status = ST_DUP;
                        n_state  = S_DONE;
                    end else begin
                        n_res_key = i_rd_key;
                        n_res_pay = i_rd_pay;
                        if (r_cmd == CMD_REMOVE) begin
                            n_idx   = r_idx + 1'b1;
                            n_state = S_SHIFT_REM;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                end else begin
                    if (r_cmd != CMD_INSERT) begin
                        n_status = ST_NOTFOUND;
                        n_state  = S_DONE;
                    end else if (full) begin
                        n_status = ST_FULL;
                        n_state  = S_DONE;
                    end else begin
                        o_wr_en     = 1'b1;
                        n_carry_key = i_rd_key;
                        n_carry_pay = i_rd_pay;
                        n_res_key   = r_key;
                        n_res_pay   = r_pay;
                        n_idx       = r_idx + 1'b1;
                        n_state     = S_SHIFT_INS;
                    end
                end
            end
            S_SHIFT_INS: begin
                o_wr_en  = 1'b1;
                o_wr_key = r_carry_key;
                o_wr_pay = r_carry_pay;
                if (at_end) begin
                    n_count = r_count + 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_carry_key = i_rd_key;
                    n_carry_pay = i_rd_pay;
                    n_idx       = r_idx + 1'b1;
                end
            end
            S_SHIFT_REM: begin
                if (at_end) begin
                    n_count = r_count - 1'b1;
                    n_state = S_DONE;
                end else begin
                    o_wr_en   = 1'b1;
                    o_wr_addr = AW'(r_idx - 1'b1);
                    o_wr_key  = i_rd_key;
                    o_wr_pay  = i_rd_pay;
                    n_idx     = r_idx + 1'b1;
                end
            end
            S_RANK: begin
                n_res_key = i_rd_key;
                n_res_pay = i_rd_pay;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (i_res_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // read one slot ahead so the data lines up with r_idx
    assign o_rd_addr = n_idx[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_key       <= n_key;
        r_pay       <= n_pay;
        r_carry_key <= n_carry_key;
        r_carry_pay <= n_carry_pay;
        r_status    <= n_status;
        r_res_key   <= n_res_key;
        r_res_pay   <= n_res_pay;
    end

    assign o_busy            = r_state != S_IDLE;
    assign o_done            = r_state == S_DONE;
    assign o_res.status      = r_status;
    assign o_res.out_key     = r_res_key;
    assign o_res.out_payload = 16'(r_res_pay);
    assign o_res.entry_count = 7'(r_count);

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN || r_state == S_SHIFT_INS || r_state == S_SHIFT_REM)
        |-> r_idx <= r_count)
        else $error("walk index past fill");

    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr_en |-> (r_state == S_SCAN || r_state == S_SHIFT_INS
                     || r_state == S_SHIFT_REM))
        else $error("table write outside walk");

    a_count_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(r_count)) |-> r_state == S_DONE)
        else $error("entry count changed mid item");
`endif

endmodule

// ===== design/sorted_key_table_core.sv =====
// ----------------------------------------------------------------------------
// sorted_key_table_core
// Ordered key table with insert, find, remove and read-at-rank commands.
// ----------------------------------------------------------------------------
// One item is handled at a time. Insert, find and remove walk the table one
// slot per cycle from the smallest key, comparing against the single read
// port of the memory; insert shifts later entries up and remove shifts them
// down within the same walk. Find and rejected commands stop at the slot
// where the walk ends; a successful insert or remove walks on to the last
// entry. Read-at-rank reads its slot directly. The result sits in an output
// register so the next item may enter while it waits; the input stalls
// while an item is at work. The memory needs no clearing after reset.
module sorted_key_table_core
    import sktab_pkg::*;
#(
    parameter int DEPTH        = 64,
    parameter int PAYLOAD_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam int AW = $clog2(DEPTH);

    logic                    start;
    logic                    busy;
    logic                    done;
    logic                    res_free;
    t_out_item               res;
    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    logic signed [31:0]      wr_key;
    logic [PAYLOAD_BITS-1:0] wr_pay;
    logic [AW-1:0]           rd_addr;
    logic signed [31:0]      rd_key;
    logic [PAYLOAD_BITS-1:0] rd_pay;

    logic      r_out_valid;
    t_out_item r_out_item;

    assign o_in_stall = busy;
    assign start      = i_in_valid && !busy;
    assign res_free   = !r_out_valid || !i_out_stall;

    sktab_seq #(
        .DEPTH        (DEPTH),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_item     (i_in_item),
        .i_res_free (res_free),
        .o_busy     (busy),
        .o_done     (done),
        .o_res      (res),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_key   (wr_key),
        .o_wr_pay   (wr_pay),
        .o_rd_addr  (rd_addr),
        .i_rd_key   (rd_key),
        .i_rd_pay   (rd_pay)
    );

    sktab_store #(
        .DEPTH        (DEPTH),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_key  (wr_key),
        .i_wr_pay  (wr_pay),
        .i_rd_addr (rd_addr),
        .o_rd_key  (rd_key),
        .o_rd_pay  (rd_pay)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done && res_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done && res_free) begin
            r_out_item <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
